[src/srsw_pkg.sv]
package srsw_pkg;

    // Fixed field widths
    localparam int CMD_W       = 2;
    localparam int SEQ_W       = 6;
    localparam int WIN_REG_W   = 5;
    localparam int PC_REG_W    = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // Register reset values
    localparam logic [WIN_REG_W-1:0] WIN_LEN_RESET      = 5'd4;
    localparam logic [PC_REG_W-1:0]  PACKET_COUNT_RESET = 7'd10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_LEN      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKET_COUNT = 2'd1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SEQ_W-1:0] ack_seq;
    } request_t;

    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] send_seq;
        logic             is_resend;
        logic             ack_rejected;
        logic             all_done;
        logic             last;
    } result_t;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_FILL,
        OP_RESEND,
        OP_STATUS
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     rejected;
        logic     done;
    } op_t;

endpackage

[src/srsw_front.sv]
module srsw_front #(
    parameter int MAX_PACKETS = 64,
    parameter int MAX_WINDOW  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  srsw_pkg::request_t                  request,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [srsw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                push,
    output srsw_pkg::op_t                       push_op,
    output logic [$clog2(MAX_PACKETS+1)-1:0]    acked_high_plus_one,
    output logic [$clog2(MAX_PACKETS+1)-1:0]    eff_count,
    output logic [$clog2(MAX_WINDOW+1)-1:0]     eff_window,
    output logic [MAX_PACKETS-1:0]              acked_map
);

    localparam int CNT_W  = $clog2(MAX_PACKETS + 1);
    localparam int IDX_W  = $clog2(MAX_PACKETS);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > srsw_pkg::PC_REG_W ? CNT_W : srsw_pkg::PC_REG_W) + 1;
    localparam int WCMP_W = (WIN_W > srsw_pkg::WIN_REG_W ? WIN_W : srsw_pkg::WIN_REG_W) + 1;

    logic [srsw_pkg::WIN_REG_W-1:0] win_len_reg;
    logic [srsw_pkg::PC_REG_W-1:0]  packet_count_reg;
    logic [CNT_W-1:0]               ahp1_reg, ahp1_next;
    logic [MAX_PACKETS-1:0]         map_reg, map_next;

    logic             ack_ok;
    logic             done_now;
    logic             done_after;
    logic [CNT_W-1:0] ahp1_after;
    logic [IDX_W-1:0] ack_idx;

    // Saturate the registers to what the storage can hold
    assign eff_count = (CMP_W'(packet_count_reg) < CMP_W'(MAX_PACKETS))
                     ? CNT_W'(packet_count_reg) : CNT_W'(MAX_PACKETS);
    assign eff_window = (WCMP_W'(win_len_reg) < WCMP_W'(MAX_WINDOW))
                      ? WIN_W'(win_len_reg) : WIN_W'(MAX_WINDOW);

    assign ack_ok = (CMP_W'(request.ack_seq) >= CMP_W'(ahp1_reg))
                 && (CMP_W'(request.ack_seq) < CMP_W'(eff_count));
    assign ack_idx    = IDX_W'(request.ack_seq);
    assign ahp1_after = ack_ok ? (CNT_W'(request.ack_seq) + CNT_W'(1)) : ahp1_reg;
    assign done_now   = ahp1_reg >= eff_count;
    assign done_after = ahp1_after >= eff_count;

    assign push = start && !busy;

    always_comb
    begin
        ahp1_next        = ahp1_reg;
        map_next         = map_reg;
        push_op.kind     = srsw_pkg::OP_STATUS;
        push_op.rejected = 1'b0;
        push_op.done     = done_now;
        unique case (request.command)
            srsw_pkg::CMD_START:
            begin
                push_op.kind = done_now ? srsw_pkg::OP_STATUS : srsw_pkg::OP_FILL;
            end
            srsw_pkg::CMD_ACK:
            begin
                if (ack_ok)
                begin
                    ahp1_next        = ahp1_after;
                    map_next[ack_idx] = 1'b1;
                end
                push_op.rejected = !ack_ok;
                push_op.done     = done_after;
                push_op.kind     = done_after ? srsw_pkg::OP_STATUS : srsw_pkg::OP_FILL;
            end
            srsw_pkg::CMD_TIMEOUT:
            begin
                push_op.kind = done_now ? srsw_pkg::OP_STATUS : srsw_pkg::OP_RESEND;
            end
            default:
            begin
                push_op.kind = srsw_pkg::OP_STATUS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg      <= srsw_pkg::WIN_LEN_RESET;
            packet_count_reg <= srsw_pkg::PACKET_COUNT_RESET;
            ahp1_reg         <= '0;
            map_reg          <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == srsw_pkg::REG_WIN_LEN)
                    win_len_reg <= cfg_data[srsw_pkg::WIN_REG_W-1:0];
                else if (cfg_index == srsw_pkg::REG_PACKET_COUNT)
                    packet_count_reg <= cfg_data[srsw_pkg::PC_REG_W-1:0];
            end
            if (push)
            begin
                ahp1_reg <= ahp1_next;
                map_reg  <= map_next;
            end
        end
    end

    assign acked_high_plus_one = ahp1_reg;
    assign acked_map           = map_reg;

    // An accepted acknowledgement always moves the window edge forward
    a_ack_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (push && request.command == srsw_pkg::CMD_ACK && ack_ok)
            |=> (ahp1_reg > $past(ahp1_reg)))
        else $error("accepted acknowledgement did not advance the window edge");

endmodule

[src/srsw_queue.sv]
module srsw_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  srsw_pkg::op_t push_op,
    input  logic          pop,
    output logic          empty,
    output srsw_pkg::op_t head_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    srsw_pkg::op_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             full;

    assign empty   = count_reg == '0;
    assign full    = count_reg == CNT_W'(DEPTH);
    assign head_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("operation queue overflow");

endmodule

[src/srsw_back.sv]
module srsw_back #(
    parameter int MAX_PACKETS = 64,
    parameter int MAX_WINDOW  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             queue_empty,
    input  srsw_pkg::op_t                    queue_op,
    input  logic [$clog2(MAX_PACKETS+1)-1:0] acked_high_plus_one,
    input  logic [$clog2(MAX_PACKETS+1)-1:0] eff_count,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]  eff_window,
    input  logic [MAX_PACKETS-1:0]           acked_map,
    output logic                             pop,
    output logic                             active,
    output logic                             result_valid,
    output srsw_pkg::result_t                result
);

    localparam int CNT_W = $clog2(MAX_PACKETS + 1);
    localparam int IDX_W = $clog2(MAX_PACKETS);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int LIM_W = (CNT_W > WIN_W ? CNT_W : WIN_W) + 1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                     state_reg, state_next;
    srsw_pkg::op_t              op_reg, op_next;
    logic [CNT_W-1:0]           nts_reg, nts_next;
    logic [CNT_W-1:0]           ptr_reg, ptr_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [srsw_pkg::SEQ_W-1:0] pend_seq_reg, pend_seq_next;
    logic                       res_valid_reg, res_valid_next;
    srsw_pkg::result_t          res_reg, res_next;

    logic [CNT_W-1:0] cur_seq;
    logic [LIM_W-1:0] limit;
    logic             in_range;
    logic             hit;

    assign limit   = LIM_W'(acked_high_plus_one) + LIM_W'(eff_window);
    assign cur_seq = (op_reg.kind == srsw_pkg::OP_RESEND) ? ptr_reg : nts_reg;
    assign hit     = in_range && !acked_map[cur_seq[IDX_W-1:0]];

    always_comb
    begin
        case (op_reg.kind)
            srsw_pkg::OP_FILL:
                in_range = (nts_reg < eff_count) && (LIM_W'(nts_reg) < limit);
            srsw_pkg::OP_RESEND:
                in_range = (ptr_reg < nts_reg) && (ptr_reg < eff_count);
            default:
                in_range = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        nts_next        = nts_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_seq_next   = pend_seq_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        pop             = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop             = 1'b1;
                    op_next         = queue_op;
                    ptr_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (in_range)
                begin
                    // Advance one sequence; release the held send once another follows
                    if (op_reg.kind == srsw_pkg::OP_RESEND)
                        ptr_next = ptr_reg + CNT_W'(1);
                    else
                        nts_next = nts_reg + CNT_W'(1);
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_next        = 1'b1;
                            res_next.send_valid   = 1'b1;
                            res_next.send_seq     = pend_seq_reg;
                            res_next.is_resend    = op_reg.kind == srsw_pkg::OP_RESEND;
                            res_next.ack_rejected = op_reg.rejected;
                            res_next.all_done     = op_reg.done;
                            res_next.last         = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_seq_next   = srsw_pkg::SEQ_W'(cur_seq);
                    end
                end
                else
                begin
                    // Close the item: held send, or a bare status result
                    res_valid_next        = 1'b1;
                    res_next.send_valid   = pend_valid_reg;
                    res_next.send_seq     = pend_valid_reg ? pend_seq_reg : '0;
                    res_next.is_resend    = pend_valid_reg
                                         && (op_reg.kind == srsw_pkg::OP_RESEND);
                    res_next.ack_rejected = op_reg.rejected;
                    res_next.all_done     = op_reg.done;
                    res_next.last         = 1'b1;
                    pend_valid_next       = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '{kind: srsw_pkg::OP_STATUS, rejected: 1'b0, done: 1'b0};
            nts_reg        <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_seq_reg   <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            nts_reg        <= nts_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            pend_seq_reg   <= pend_seq_next;
            res_valid_reg  <= res_valid_next;
            res_reg        <= res_next;
        end
    end

    assign active       = state_reg != S_IDLE;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_SCAN))
        else $error("held send outside a scan");

    a_status_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && op_reg.kind == srsw_pkg::OP_STATUS)
            |=> (state_reg == S_IDLE && res_valid_reg && res_reg.last))
        else $error("status item did not close in one step");

endmodule

[src/selective_repeat_sender_window.sv]
// Sender window of a selective-repeat retransmission scheme. Pulse start with a command
// (start, acknowledgement received, timeout) while busy is low; the block answers with one
// or more results, each shown for exactly one cycle under result_valid, the final one
// carrying last. The receiver cannot stall: sample every strobe. An item that sends
// nothing still yields one status result with send_valid low. The back-end scan makes a
// single acknowledged-bitmap lookup per cycle, one sequence at a time; it covers, for
// start and acknowledgement, every sequence from next-to-send up to the lower
// of the packet count and the window edge (one past the highest accepted acknowledgement
// plus the window length), which can exceed the window length when an acknowledgement
// jumps ahead of what has been sent; for timeout every sequence already sent (at most the
// packet count). busy falls in the cycle that carries the last result, so the next
// start may coincide with it.
// Configuration writes are always taken (cfg_ready is high) and belong in idle periods.
module selective_repeat_sender_window #(
    parameter int MAX_PACKETS = 64,
    parameter int MAX_WINDOW  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  srsw_pkg::request_t               request,
    output logic                             result_valid,
    output srsw_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_PACKETS + 1);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);

    logic                   push;
    srsw_pkg::op_t          push_op;
    logic                   pop;
    logic                   queue_empty;
    srsw_pkg::op_t          queue_op;
    logic                   back_active;
    logic [CNT_W-1:0]       acked_high_plus_one;
    logic [CNT_W-1:0]       eff_count;
    logic [WIN_W-1:0]       eff_window;
    logic [MAX_PACKETS-1:0] acked_map;

    // Hold off new commands while anything is queued or being scanned
    assign busy      = !queue_empty || back_active;
    assign cfg_ready = 1'b1;

    // Front end: take the command transfer, apply the acknowledgement, classify the work
    srsw_front #(
        .MAX_PACKETS (MAX_PACKETS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .request             (request),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .push                (push),
        .push_op             (push_op),
        .acked_high_plus_one (acked_high_plus_one),
        .eff_count           (eff_count),
        .eff_window          (eff_window),
        .acked_map           (acked_map)
    );

    // Short queue between classification and scanning
    srsw_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .empty   (queue_empty),
        .head_op (queue_op)
    );

    // Back end: walk the bitmap one sequence a cycle and drive the result register
    srsw_back #(
        .MAX_PACKETS (MAX_PACKETS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .queue_empty         (queue_empty),
        .queue_op            (queue_op),
        .acked_high_plus_one (acked_high_plus_one),
        .eff_count           (eff_count),
        .eff_window          (eff_window),
        .acked_map           (acked_map),
        .pop                 (pop),
        .active              (back_active),
        .result_valid        (result_valid),
        .result              (result)
    );

    // A taken command keeps the block busy until its last result
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a command transfer");

    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("busy dropped before the last result");

endmodule

[sim/srsw_checker.sv]
module srsw_checker #(
    parameter int MAX_PACKETS = 64,
    parameter int MAX_WINDOW  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  srsw_pkg::request_t               request,
    input  logic                             result_valid,
    input  srsw_pkg::result_t                result,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [srsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               pending,
    output logic [6:0]                       acked_upto,
    output int                               items_seen,
    output int                               sends_seen,
    output int                               resends_seen,
    output int                               refusals_seen
);

    // mirror of the sender window state
    logic [MAX_PACKETS-1:0]           acked_bits;
    logic [7:0]                       next_seq;
    logic [7:0]                       high_plus_one;
    logic [srsw_pkg::WIN_REG_W-1:0]   window_reg;
    logic [srsw_pkg::PC_REG_W-1:0]    count_reg;

    srsw_pkg::result_t expected_q[$];
    srsw_pkg::result_t want;
    int                errors;
    int                n_items;
    int                n_sends;
    int                n_resends;
    int                n_refusals;

    // Work out every result of one accepted request and queue it.
    task automatic predict_window(input srsw_pkg::request_t req);
        srsw_pkg::result_t batch [MAX_PACKETS];
        logic [7:0]        count_lim;
        logic [7:0]        win_lim;
        logic [7:0]        window_end;
        logic [7:0]        scan_end;
        logic [7:0]        s;
        logic              refused;
        logic              finished;
        int                k;
        k = 0;
        refused = 1'b0;
        count_lim = (count_reg < MAX_PACKETS) ? {1'b0, count_reg} : 8'(MAX_PACKETS);
        win_lim = (window_reg < MAX_WINDOW) ? {3'b000, window_reg} : 8'(MAX_WINDOW);

        if (req.command == srsw_pkg::CMD_ACK)
        begin
            if ({2'b00, req.ack_seq} >= high_plus_one && {2'b00, req.ack_seq} < count_lim)
            begin
                high_plus_one = {2'b00, req.ack_seq} + 8'd1;
                acked_bits[req.ack_seq] = 1'b1;
            end
            else
            begin
                refused = 1'b1;
                n_refusals++;
            end
        end
        finished = (high_plus_one >= count_lim);

        if (!finished && (req.command == srsw_pkg::CMD_START
                          || req.command == srsw_pkg::CMD_ACK))
        begin
            window_end = high_plus_one + win_lim;
            while (next_seq < count_lim && next_seq < window_end && k < MAX_PACKETS)
            begin
                if (!acked_bits[next_seq])
                begin
                    batch[k] = '0;
                    batch[k].send_valid = 1'b1;
                    batch[k].send_seq = next_seq[srsw_pkg::SEQ_W-1:0];
                    k++;
                end
                next_seq = next_seq + 8'd1;
            end
        end
        else if (!finished && req.command == srsw_pkg::CMD_TIMEOUT)
        begin
            // resend only what has gone out, clipped to the current packet count
            scan_end = (next_seq < count_lim) ? next_seq : count_lim;
            for (s = 8'd0; s < scan_end && k < MAX_PACKETS; s = s + 8'd1)
            begin
                if (!acked_bits[s])
                begin
                    batch[k] = '0;
                    batch[k].send_valid = 1'b1;
                    batch[k].send_seq = s[srsw_pkg::SEQ_W-1:0];
                    batch[k].is_resend = 1'b1;
                    k++;
                end
            end
        end

        if (k == 0)
        begin
            batch[0] = '0;
            k = 1;
        end
        for (int i = 0; i < k; i++)
        begin
            batch[i].ack_rejected = refused;
            batch[i].all_done = finished;
            batch[i].last = (i == k - 1);
            expected_q.push_back(batch[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_bits = '0;
            next_seq = '0;
            high_plus_one = '0;
            window_reg = srsw_pkg::WIN_LEN_RESET;
            count_reg = srsw_pkg::PACKET_COUNT_RESET;
            expected_q.delete();
            errors = 0;
            n_items = 0;
            n_sends = 0;
            n_resends = 0;
            n_refusals = 0;
            mismatches <= 0;
            pending <= 0;
            acked_upto <= '0;
            items_seen <= 0;
            sends_seen <= 0;
            resends_seen <= 0;
            refusals_seen <= 0;
        end
        else
        begin
            // results first: the last one of a request may share an edge with the next
            if (result_valid === 1'b1)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: valid=%b seq=%0d resend=%b",
                             $time, result.send_valid, result.send_seq, result.is_resend);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.send_valid !== want.send_valid ||
                        result.send_seq !== want.send_seq ||
                        result.is_resend !== want.is_resend ||
                        result.ack_rejected !== want.ack_rejected ||
                        result.all_done !== want.all_done ||
                        result.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: expected valid=%b seq=%0d resend=%b rej=%b done=%b last=%b",
                                 $time, want.send_valid, want.send_seq, want.is_resend,
                                 want.ack_rejected, want.all_done, want.last);
                        $display("%0t: actual   valid=%b seq=%0d resend=%b rej=%b done=%b last=%b",
                                 $time, result.send_valid, result.send_seq, result.is_resend,
                                 result.ack_rejected, result.all_done, result.last);
                    end
                    else if (want.send_valid)
                    begin
                        if (want.is_resend)
                            n_resends++;
                        else
                            n_sends++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    srsw_pkg::REG_WIN_LEN:
                        window_reg = cfg_data[srsw_pkg::WIN_REG_W-1:0];
                    srsw_pkg::REG_PACKET_COUNT:
                        count_reg = cfg_data[srsw_pkg::PC_REG_W-1:0];
                    default: ;
                endcase
            end

            if (start && !busy)
            begin
                predict_window(request);
                n_items++;
            end

            mismatches <= errors;
            pending <= expected_q.size();
            acked_upto <= high_plus_one[6:0];
            items_seen <= n_items;
            sends_seen <= n_sends;
            resends_seen <= n_resends;
            refusals_seen <= n_refusals;
        end
    end

endmodule

[sim/tb_selective_repeat_sender_window.sv]
module tb_selective_repeat_sender_window;

    // no named code exists for the spare command value
    localparam logic [srsw_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int SETTLE_CYCLES   = 8;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             start     = 1'b0;
    srsw_pkg::request_t               request   = '0;
    logic                             cfg_valid = 1'b0;
    logic [srsw_pkg::CFG_INDEX_W-1:0] cfg_index = srsw_pkg::REG_WIN_LEN;
    logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             busy;
    logic                             result_valid;
    srsw_pkg::result_t                result;
    logic                             cfg_ready;

    int         mismatches;
    int         pending;
    logic [6:0] acked_upto;
    int         items_seen;
    int         sends_seen;
    int         resends_seen;
    int         refusals_seen;

    // When set, requests go in back to back with no gap between transfers.
    logic no_idle = 1'b0;

    // Register settings of the random phases: zero, saturated and shrunk values
    // are all in here, and the packet count mostly climbs so the transfer keeps going.
    logic [srsw_pkg::WIN_REG_W-1:0] phase_window [PHASES] =
        '{5'd1, 5'd0, 5'd16, 5'd31, 5'd7, 5'd17, 5'd3, 5'd16, 5'd9, 5'd12};
    logic [srsw_pkg::PC_REG_W-1:0]  phase_count  [PHASES] =
        '{7'd16, 7'd24, 7'd0, 7'd32, 7'd28, 7'd40, 7'd52, 7'd127, 7'd64, 7'd100};

    always #1 clk = ~clk;

    selective_repeat_sender_window dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    srsw_checker window_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_valid  (result_valid),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .acked_upto    (acked_upto),
        .items_seen    (items_seen),
        .sends_seen    (sends_seen),
        .resends_seen  (resends_seen),
        .refusals_seen (refusals_seen)
    );

    // Offer one request after a random gap and hold it until the transfer.
    // start is left high so that a following request with no gap goes straight in.
    task automatic send_item(input logic [srsw_pkg::CMD_W-1:0] cmd,
                             input logic [srsw_pkg::SEQ_W-1:0] ack);
        srsw_pkg::request_t req;
        int                 gap;
        req.command = cmd;
        req.ack_seq = ack;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and hold off until every expected result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One register write; cfg_valid is dropped afterwards to keep a following write clean.
    task automatic write_reg(input logic [srsw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [srsw_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int                         roll;
        int                         pick;
        int                         n;
        logic [srsw_pkg::CMD_W-1:0] cmd;
        logic [srsw_pkg::SEQ_W-1:0] ack;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset settings (window 4, ten packets).
        send_item(srsw_pkg::CMD_TIMEOUT, 6'h3F);  // nothing sent yet: status only
        send_item(srsw_pkg::CMD_START, 6'h00);    // fill the window with 0..3
        send_item(srsw_pkg::CMD_START, 6'h15);    // window already full: status only
        send_item(srsw_pkg::CMD_ACK, 6'h3F);      // beyond the packet count: refused
        send_item(srsw_pkg::CMD_ACK, 6'h01);      // out of order, accepted; window slides
        send_item(srsw_pkg::CMD_ACK, 6'h00);      // below the window: refused
        send_item(srsw_pkg::CMD_TIMEOUT, 6'h00);  // resend the gaps
        send_item(CMD_UNKNOWN, 6'h2A);            // spare code: status only
        send_item(srsw_pkg::CMD_ACK, 6'h05);      // fill up to the packet count
        send_item(srsw_pkg::CMD_ACK, 6'h0A);      // equal to the packet count: refused
        send_item(srsw_pkg::CMD_TIMEOUT, 6'h3F);
        send_item(srsw_pkg::CMD_ACK, 6'h09);      // last packet: transfer complete
        send_item(srsw_pkg::CMD_START, 6'h00);    // complete: nothing new
        send_item(srsw_pkg::CMD_TIMEOUT, 6'h00);  // complete: nothing resent
        send_item(srsw_pkg::CMD_ACK, 6'h09);

        // Zero window and zero packet count: complete at once.
        drain();
        write_reg(srsw_pkg::REG_WIN_LEN, 7'h00);
        write_reg(srsw_pkg::REG_PACKET_COUNT, 7'h00);
        send_item(srsw_pkg::CMD_START, 6'h00);
        send_item(srsw_pkg::CMD_ACK, 6'h00);

        // Both registers above their caps: a full window of sixteen, then a long resend.
        drain();
        write_reg(srsw_pkg::REG_WIN_LEN, 7'h7F);
        write_reg(srsw_pkg::REG_PACKET_COUNT, 7'h7F);
        send_item(srsw_pkg::CMD_START, 6'h00);
        send_item(srsw_pkg::CMD_TIMEOUT, 6'h2A);
        send_item(srsw_pkg::CMD_ACK, 6'h0A);

        // Random phases. Most acknowledgements hit the window base so the transfer
        // advances one packet at a time; some skip ahead, some are plain noise.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(srsw_pkg::REG_WIN_LEN, {2'($urandom_range(0, 3)), phase_window[p]});
            write_reg(srsw_pkg::REG_PACKET_COUNT, phase_count[p]);
            no_idle = (p % 3 == 1);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                pick = $urandom_range(0, 99);
                ack = 6'($urandom);
                if (roll < 35)
                begin
                    cmd = srsw_pkg::CMD_ACK;
                    if (pick < 75)
                        ack = acked_upto[srsw_pkg::SEQ_W-1:0];
                    else if (pick < 95)
                        ack = acked_upto[srsw_pkg::SEQ_W-1:0] + 6'($urandom_range(1, 3));
                end
                else if (roll < 60)
                    cmd = srsw_pkg::CMD_TIMEOUT;
                else if (roll < 82)
                    cmd = srsw_pkg::CMD_START;
                else if (roll < 94)
                    cmd = srsw_pkg::CMD_ACK;   // random sequence: mostly refused
                else
                    cmd = CMD_UNKNOWN;
                send_item(cmd, ack);
                n++;
            end
        end

        // Let the last results out, then keep the clock running idle to catch anything stray.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d register settings, zero and saturated included.",
                 items_seen, PHASES + 3);
        $display("Checked %0d first sends, %0d resends and %0d refused acknowledgements.",
                 sends_seen, resends_seen, refusals_seen);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1000000;
        $display("Timed out with %0d results still outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
